### design/lcd_pkg.sv
// ----------------------------------------------------------------------------
// Lasso coordinate descent package
// Shared types, codes, defaults and the saturation helper for the solver block.
// ----------------------------------------------------------------------------
package lcd_pkg;

   localparam int MAX_SAMPLES_DEF  = 1024;
   localparam int MAX_FEATURES_DEF = 64;

   typedef enum logic [2:0] {
      OP_LOAD_X = 3'd0,
      OP_LOAD_Y = 3'd1,
      OP_STEP   = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_LAMBDA       = 2'd0,
      CSR_INV_SAMPLES  = 2'd1,
      CSR_NUM_SAMPLES  = 2'd2,
      CSR_NUM_FEATURES = 2'd3
   } csr_type;

   typedef enum logic [11:0] {
      ST_INIT     = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_ACC      = 12'b0000_0000_0100,
      ST_ACC_WAIT = 12'b0000_0000_1000,
      ST_DELTA    = 12'b0000_0001_0000,
      ST_ETA      = 12'b0000_0010_0000,
      ST_UPD      = 12'b0000_0100_0000,
      ST_UPD_WAIT = 12'b0000_1000_0000,
      ST_RD1      = 12'b0001_0000_0000,
      ST_RD2      = 12'b0010_0000_0000,
      ST_RD3      = 12'b0100_0000_0000,
      ST_EMIT     = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr;
      logic acc_issue;
      logic loop_init;
      logic delta;
      logic eta;
      logic upd_issue;
      logic rd2;
      logic rd3;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_err;
      logic last;
      logic busy;
      logic clr_last;
      logic ns_zero;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > $signed(66'h0_7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -$signed(66'h0_8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### design/lcd_datapath.sv
// ----------------------------------------------------------------------------
// Lasso coordinate descent datapath
// Configuration registers, sample and weight memories, accumulate and
// residual update pipelines, and the result register.
// ----------------------------------------------------------------------------
module lcd_datapath #(
   parameter int MAX_SAMPLES  = lcd_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_FEATURES = lcd_pkg::MAX_FEATURES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lcd_pkg::cmd_type    cmd,
   output lcd_pkg::sts_type    sts,
   input  logic [2:0]          req_op,
   input  logic [9:0]          req_sample_index,
   input  logic [6:0]          req_feature_index,
   input  logic signed [31:0]  req_value,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic signed [31:0]  rsp_weight,
   output logic signed [31:0]  rsp_step_size,
   output logic                rsp_index_error
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SCMP_W = (CNT_W > 11) ? CNT_W : 11;
   localparam int SA_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FCNT_W = $clog2(MAX_FEATURES + 1);
   localparam int FCMP_W = ((FCNT_W > 7) ? FCNT_W : 7) + 1;
   localparam int FA_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int WDEPTH = 2 * MAX_FEATURES;
   localparam int WA_W   = $clog2(WDEPTH);
   localparam int XDEPTH = MAX_SAMPLES * MAX_FEATURES;
   localparam int XA_W   = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
   localparam int CLR_N  = (MAX_SAMPLES > WDEPTH) ? MAX_SAMPLES : WDEPTH;
   localparam int CLR_W  = $clog2(CLR_N);

   logic [30:0] lambda_ff;
   logic [31:0] inv_ff;
   logic [10:0] nsamp_ff;
   logic [6:0]  nfeat_ff;

   logic signed [31:0] x_mem [XDEPTH];
   logic signed [31:0] y_mem [MAX_SAMPLES];
   logic signed [31:0] z_mem [MAX_SAMPLES];
   logic signed [31:0] w_mem [WDEPTH];

   logic signed [31:0] x_rd_ff, y_rd_ff, z_rd_ff, w_rd_ff;

   logic [SCMP_W-1:0] ns_eff, si_ext;
   logic [FCMP_W-1:0] nf_eff, nf2, fi_ext, col_ext, rdb_ext;
   logic              si_bad, fi_bad, step_bad, neg_in, req_err;
   lcd_pkg::op_type   op;

   logic [WA_W-1:0]  fi_w_ff, rdb_ff, w_ra, w_wa;
   logic             neg_ff;
   logic [FA_W-1:0]  col_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [XA_W-1:0]  xb_ff, xl_addr;
   logic [SA_W-1:0]  sa;
   logic [CLR_W-1:0] clr_ff;
   logic             clr_z, clr_w;

   logic a_rd_ff, a1_ff, a2_ff, u_rd_ff, u1_ff;
   logic signed [31:0] d_ff, xa1_ff, eta_ff, uz_ff, wa_ff;
   logic signed [63:0] p_ff, up_ff, acc_ff, pn, upn;
   logic signed [64:0] prod_ff;
   logic [SA_W-1:0]    ua0_ff, ua1_ff;

   logic signed [31:0] acc_sat, delta, eta, wnew, znew, rdw;
   logic signed [33:0] nw, nd, mx;

   logic signed [31:0] res_w_ff, res_s_ff;
   logic               res_e_ff;
   logic signed [31:0] rsp_w_ff, rsp_s_ff;
   logic               rsp_e_ff;

   logic x_we, y_we, z_we, w_we;
   logic signed [31:0] z_wd, w_wd;
   logic [SA_W-1:0]    z_wa;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= '0;
         inv_ff    <= 32'h8000_0000;
         nsamp_ff  <= 11'd1;
         nfeat_ff  <= 7'd1;
      end else if (csr_write) begin
         unique case (lcd_pkg::csr_type'(csr_index))
            lcd_pkg::CSR_LAMBDA:       lambda_ff <= csr_wdata[30:0];
            lcd_pkg::CSR_INV_SAMPLES:  inv_ff    <= csr_wdata;
            lcd_pkg::CSR_NUM_SAMPLES:  nsamp_ff  <= csr_wdata[10:0];
            lcd_pkg::CSR_NUM_FEATURES: nfeat_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      op       = lcd_pkg::op_type'(req_op);
      ns_eff   = (SCMP_W'(nsamp_ff) > SCMP_W'(MAX_SAMPLES)) ? SCMP_W'(MAX_SAMPLES)
                                                            : SCMP_W'(nsamp_ff);
      nf_eff   = (FCMP_W'(nfeat_ff) > FCMP_W'(MAX_FEATURES)) ? FCMP_W'(MAX_FEATURES)
                                                             : FCMP_W'(nfeat_ff);
      nf2      = nf_eff + nf_eff;
      si_ext   = SCMP_W'(req_sample_index);
      fi_ext   = FCMP_W'(req_feature_index);
      si_bad   = si_ext >= ns_eff;
      fi_bad   = fi_ext >= nf_eff;
      step_bad = fi_ext >= nf2;
      neg_in   = fi_ext >= nf_eff;
      col_ext  = neg_in ? fi_ext - nf_eff : fi_ext;
      rdb_ext  = nf_eff + fi_ext;
      unique case (op)
         lcd_pkg::OP_LOAD_X: req_err = si_bad | fi_bad;
         lcd_pkg::OP_LOAD_Y: req_err = si_bad;
         lcd_pkg::OP_STEP:   req_err = step_bad;
         lcd_pkg::OP_READ:   req_err = fi_bad;
         default:            req_err = 1'b0;
      endcase
      xl_addr = XA_W'(si_ext[SA_W-1:0]) * XA_W'(MAX_FEATURES) + XA_W'(fi_ext[FA_W-1:0]);
      sa      = cnt_ff[SA_W-1:0];
      clr_z   = {1'b0, clr_ff} < (CLR_W + 1)'(MAX_SAMPLES);
      clr_w   = {1'b0, clr_ff} < (CLR_W + 1)'(WDEPTH);
   end

   assign sts.req_err  = req_err;
   assign sts.last     = (SCMP_W'(cnt_ff) + SCMP_W'(1)) == ns_eff;
   assign sts.busy     = a_rd_ff | a1_ff | a2_ff | u_rd_ff | u1_ff;
   assign sts.clr_last = clr_ff == CLR_W'(CLR_N - 1);
   assign sts.ns_zero  = ns_eff == '0;

   // Arithmetic between the pipeline registers.
   always_comb begin
      pn      = neg_ff ? -p_ff : p_ff;
      upn     = neg_ff ? -up_ff : up_ff;
      acc_sat = lcd_pkg::sat32(66'(acc_ff));
      delta   = lcd_pkg::sat32(66'(prod_ff >>> 31));
      nw      = -34'(w_rd_ff);
      nd      = -34'(delta);
      mx      = (nw > nd) ? nw : nd;
      eta     = lcd_pkg::sat32(66'(mx));
      wnew    = lcd_pkg::sat32(66'(w_rd_ff) + 66'(eta));
      znew    = lcd_pkg::sat32(66'(uz_ff) + 66'(upn >>> 16));
      rdw     = lcd_pkg::sat32(66'(wa_ff) - 66'(w_rd_ff));
   end

   always_comb begin
      x_we = cmd.accept && (op == lcd_pkg::OP_LOAD_X) && !req_err;
      y_we = cmd.accept && (op == lcd_pkg::OP_LOAD_Y) && !req_err;
      z_we = (cmd.clr && clr_z) || u1_ff;
      z_wa = cmd.clr ? clr_ff[SA_W-1:0] : ua1_ff;
      z_wd = cmd.clr ? 32'sd0 : znew;
      w_we = (cmd.clr && clr_w) || cmd.eta;
      w_wa = cmd.clr ? clr_ff[WA_W-1:0] : fi_w_ff;
      w_wd = cmd.clr ? 32'sd0 : wnew;
      w_ra = cmd.rd2 ? rdb_ff : fi_w_ff;
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[xl_addr] <= req_value;
      end
      x_rd_ff <= x_mem[xb_ff];
   end

   always_ff @(posedge clock) begin
      if (y_we) begin
         y_mem[si_ext[SA_W-1:0]] <= req_value;
      end
      y_rd_ff <= y_mem[sa];
   end

   always_ff @(posedge clock) begin
      if (z_we) begin
         z_mem[z_wa] <= z_wd;
      end
      z_rd_ff <= z_mem[sa];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_wa] <= w_wd;
      end
      w_rd_ff <= w_mem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         a_rd_ff <= 1'b0;
         a1_ff   <= 1'b0;
         a2_ff   <= 1'b0;
         u_rd_ff <= 1'b0;
         u1_ff   <= 1'b0;
      end else begin
         if (cmd.clr) begin
            clr_ff <= sts.clr_last ? '0 : clr_ff + CLR_W'(1);
         end
         a_rd_ff <= cmd.acc_issue;
         a1_ff   <= a_rd_ff;
         a2_ff   <= a1_ff;
         u_rd_ff <= cmd.upd_issue;
         u1_ff   <= u_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fi_w_ff <= fi_ext[WA_W-1:0];
         rdb_ff  <= rdb_ext[WA_W-1:0];
         neg_ff  <= neg_in;
         col_ff  <= col_ext[FA_W-1:0];
         acc_ff  <= $signed({33'd0, lambda_ff});
      end else if (a2_ff) begin
         acc_ff <= acc_ff + (pn >>> 16);
      end
      if (cmd.accept) begin
         cnt_ff <= '0;
         xb_ff  <= XA_W'(col_ext[FA_W-1:0]);
      end else if (cmd.loop_init) begin
         cnt_ff <= '0;
         xb_ff  <= XA_W'(col_ff);
      end else if (cmd.acc_issue || cmd.upd_issue) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         xb_ff  <= xb_ff + XA_W'(MAX_FEATURES);
      end
      d_ff   <= lcd_pkg::sat32(66'(z_rd_ff) - 66'(y_rd_ff));
      xa1_ff <= x_rd_ff;
      p_ff   <= 64'(d_ff) * 64'(xa1_ff);
      if (cmd.delta) begin
         prod_ff <= 65'(acc_sat) * $signed({33'd0, inv_ff});
      end
      if (cmd.eta) begin
         eta_ff <= eta;
      end
      ua0_ff <= sa;
      ua1_ff <= ua0_ff;
      up_ff  <= 64'(eta_ff) * 64'(x_rd_ff);
      uz_ff  <= z_rd_ff;
      if (cmd.rd2) begin
         wa_ff <= w_rd_ff;
      end
      if (cmd.accept && req_err) begin
         res_w_ff <= '0;
         res_s_ff <= '0;
         res_e_ff <= 1'b1;
      end else if (cmd.eta) begin
         res_w_ff <= wnew;
         res_s_ff <= eta;
         res_e_ff <= 1'b0;
      end else if (cmd.rd3) begin
         res_w_ff <= rdw;
         res_s_ff <= '0;
         res_e_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_w_ff <= res_w_ff;
         rsp_s_ff <= res_s_ff;
         rsp_e_ff <= res_e_ff;
      end
   end

   assign rsp_weight      = rsp_w_ff;
   assign rsp_step_size   = rsp_s_ff;
   assign rsp_index_error = rsp_e_ff;

endmodule

### design/lcd_controller.sv
// ----------------------------------------------------------------------------
// Lasso coordinate descent controller
// Sequences clearing, loads, descent steps and weight reads, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module lcd_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_op,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lcd_pkg::cmd_type cmd,
   input  lcd_pkg::sts_type sts
);

   lcd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         lcd_pkg::ST_INIT: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = lcd_pkg::ST_IDLE;
         end
         lcd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (lcd_pkg::op_type'(req_op))
                  lcd_pkg::OP_LOAD_X, lcd_pkg::OP_LOAD_Y: begin
                     if (sts.req_err) state_in = lcd_pkg::ST_EMIT;
                  end
                  lcd_pkg::OP_STEP: begin
                     if (sts.req_err) state_in = lcd_pkg::ST_EMIT;
                     else if (sts.ns_zero) state_in = lcd_pkg::ST_DELTA;
                     else state_in = lcd_pkg::ST_ACC;
                  end
                  lcd_pkg::OP_READ: begin
                     if (sts.req_err) state_in = lcd_pkg::ST_EMIT;
                     else state_in = lcd_pkg::ST_RD1;
                  end
                  lcd_pkg::OP_CLEAR: state_in = lcd_pkg::ST_INIT;
                  default: ;
               endcase
            end
         end
         lcd_pkg::ST_ACC: begin
            cmd.acc_issue = 1'b1;
            if (sts.last) state_in = lcd_pkg::ST_ACC_WAIT;
         end
         lcd_pkg::ST_ACC_WAIT: begin
            if (!sts.busy) state_in = lcd_pkg::ST_DELTA;
         end
         lcd_pkg::ST_DELTA: begin
            cmd.delta     = 1'b1;
            cmd.loop_init = 1'b1;
            state_in      = lcd_pkg::ST_ETA;
         end
         lcd_pkg::ST_ETA: begin
            cmd.eta  = 1'b1;
            state_in = sts.ns_zero ? lcd_pkg::ST_EMIT : lcd_pkg::ST_UPD;
         end
         lcd_pkg::ST_UPD: begin
            cmd.upd_issue = 1'b1;
            if (sts.last) state_in = lcd_pkg::ST_UPD_WAIT;
         end
         lcd_pkg::ST_UPD_WAIT: begin
            if (!sts.busy) state_in = lcd_pkg::ST_EMIT;
         end
         lcd_pkg::ST_RD1: begin
            state_in = lcd_pkg::ST_RD2;
         end
         lcd_pkg::ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = lcd_pkg::ST_RD3;
         end
         lcd_pkg::ST_RD3: begin
            cmd.rd3  = 1'b1;
            state_in = lcd_pkg::ST_EMIT;
         end
         lcd_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lcd_pkg::ST_IDLE;
            end
         end
         default: state_in = lcd_pkg::ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcd_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != lcd_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/lasso_coordinate_descent_unit.sv
// ----------------------------------------------------------------------------
// Lasso coordinate descent unit
// Stochastic coordinate descent Lasso solver over duplicated weights, Q16.16.
// ----------------------------------------------------------------------------
// The request channel carries an op with a sample index, a feature index and a
// value; the response channel returns weight, step size and an index error.
// Loads that are in range are taken while idle and give no response. A read of
// a combined weight passes states RD1, RD2, RD3 and EMIT before its response
// is presented. A descent step walks the active samples twice through one
// memory read port per store; with no sample active it goes from the delta and
// eta states straight to the emit state. Requests that are out of range go
// straight to the emit state and present an error response with zero weight
// and step size. The next request can be taken in the cycle in which the
// response appears.
// After reset and after a clear request, a clearing pass writes zero to the
// residual and weight memories one entry per cycle, while requests are
// stalled; configuration writes are taken at any time the block is idle. The
// response sits in an output register; while the receiver stalls it, loads
// keep being accepted, and a request that needs a response waits until the
// register is free.
// ----------------------------------------------------------------------------
module lasso_coordinate_descent_unit #(
   parameter int MAX_SAMPLES  = lcd_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_FEATURES = lcd_pkg::MAX_FEATURES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [9:0]         req_sample_index,
   input  logic [6:0]         req_feature_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_weight,
   output logic signed [31:0] rsp_step_size,
   output logic               rsp_index_error,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   lcd_pkg::cmd_type cmd;
   lcd_pkg::sts_type sts;

   lcd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lcd_datapath #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .MAX_FEATURES (MAX_FEATURES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_sample_index  (req_sample_index),
      .req_feature_index (req_feature_index),
      .req_value         (req_value),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_weight        (rsp_weight),
      .rsp_step_size     (rsp_step_size),
      .rsp_index_error   (rsp_index_error)
   );

endmodule

### design/lcd_checker.sv
// ----------------------------------------------------------------------------
// Lasso coordinate descent checker
// Port-level assertions on the solver unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module lcd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_op,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_weight,
   input logic signed [31:0] rsp_step_size,
   input logic               rsp_index_error
);

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight)
                                 && $stable(rsp_step_size) && $stable(rsp_index_error))
      else $error("stalled response changed");

   // An error response carries zero weight and step size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_weight == 0 && rsp_step_size == 0)
      else $error("error response with nonzero data");

   // Reset starts the clearing pass.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // A clear request starts the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == lcd_pkg::OP_CLEAR |=> req_stall)
      else $error("request taken during clearing");

   // An accepted descent step stalls requests in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == lcd_pkg::OP_STEP |=> req_stall)
      else $error("request taken during a step");

endmodule

bind lasso_coordinate_descent_unit lcd_checker u_chk (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lasso coordinate descent unit testbench
// Drives loads, descent steps, weight reads and clears through several
// register settings, predicts every response with a Q16.16 solver kept in a
// scoreboard class, and compares responses field by field in order.
// ----------------------------------------------------------------------------
typedef struct {
   int w;
   int s;
   bit e;
} solver_resp_type;

class lasso_scoreboard;
   int unsigned lambda_q;
   bit [31:0] inv_samples;
   int unsigned num_samples;
   int unsigned num_features;
   int x_mem[65536];
   bit x_set[65536];
   int y_mem[1024];
   bit y_set[1024];
   int z_mem[1024];
   int w_mem[128];
   solver_resp_type pending_q[$];
   int mismatches;
   int n_steps;
   int n_reads;
   int n_errors;
   int n_checked;

   function new();
      lambda_q = 0;
      inv_samples = 32'h8000_0000;
      num_samples = 1;
      num_features = 1;
      foreach (z_mem[i]) z_mem[i] = 0;
      foreach (w_mem[i]) w_mem[i] = 0;
   endfunction

   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function int eff_ns();
      return (num_samples > 1024) ? 1024 : num_samples;
   endfunction

   function int eff_nf();
      return (num_features > 64) ? 64 : num_features;
   endfunction

   function void set_reg(lcd_pkg::csr_type idx, bit [31:0] data);
      case (idx)
         lcd_pkg::CSR_LAMBDA:       lambda_q = data[30:0];
         lcd_pkg::CSR_INV_SAMPLES:  inv_samples = data;
         lcd_pkg::CSR_NUM_SAMPLES:  num_samples = data[10:0];
         lcd_pkg::CSR_NUM_FEATURES: num_features = data[6:0];
      endcase
   endfunction

   function bit column_ready(int col);
      for (int i = 0; i < eff_ns(); i++) begin
         if (!x_set[i * 64 + col] || !y_set[i]) return 0;
      end
      return 1;
   endfunction

   function void push(longint w, longint s, bit e);
      solver_resp_type r;
      r.w = int'(w);
      r.s = int'(s);
      r.e = e;
      if (e) n_errors++;
      pending_q.insert(pending_q.size(), r);
   endfunction

   function void note_request(logic [2:0] op, int si, int fi, int val);
      int ns;
      int nf;
      int col;
      bit neg;
      longint acc;
      longint delta;
      longint eta;
      longint w;
      longint p;
      longint d;
      longint xv;
      ns = eff_ns();
      nf = eff_nf();
      case (op)
         lcd_pkg::OP_LOAD_X: begin
            if (si >= ns || fi >= nf) begin
               push(0, 0, 1);
            end else begin
               x_mem[si * 64 + fi] = val;
               x_set[si * 64 + fi] = 1;
            end
         end
         lcd_pkg::OP_LOAD_Y: begin
            if (si >= ns) begin
               push(0, 0, 1);
            end else begin
               y_mem[si] = val;
               y_set[si] = 1;
            end
         end
         lcd_pkg::OP_STEP: begin
            if (fi >= 2 * nf) begin
               push(0, 0, 1);
            end else begin
               n_steps++;
               neg = (fi >= nf);
               col = neg ? fi - nf : fi;
               acc = longint'(lambda_q);
               for (int i = 0; i < ns; i++) begin
                  xv = x_mem[i * 64 + col];
                  if (xv != 0) begin
                     d = clip32(longint'(z_mem[i]) - longint'(y_mem[i]));
                     p = d * xv;
                     if (neg) p = -p;
                     acc += p >>> 16;
                  end
               end
               acc = clip32(acc);
               delta = clip32((acc * longint'({32'b0, inv_samples})) >>> 31);
               w = w_mem[fi];
               eta = (-w > -delta) ? -w : -delta;
               eta = clip32(eta);
               w = clip32(w + eta);
               w_mem[fi] = int'(w);
               for (int i = 0; i < ns; i++) begin
                  xv = x_mem[i * 64 + col];
                  if (xv != 0) begin
                     p = eta * xv;
                     if (neg) p = -p;
                     z_mem[i] = int'(clip32(longint'(z_mem[i]) + (p >>> 16)));
                  end
               end
               push(w, eta, 0);
            end
         end
         lcd_pkg::OP_READ: begin
            if (fi >= nf) begin
               push(0, 0, 1);
            end else begin
               n_reads++;
               push(clip32(longint'(w_mem[fi]) - longint'(w_mem[nf + fi])), 0, 0);
            end
         end
         lcd_pkg::OP_CLEAR: begin
            foreach (z_mem[i]) z_mem[i] = 0;
            foreach (w_mem[i]) w_mem[i] = 0;
         end
         default: ;
      endcase
   endfunction

   function void check_response(int w, int s, bit e);
      solver_resp_type x;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected response weight %h step %h error %b", $time, w, s, e);
         mismatches++;
         return;
      end
      x = pending_q.pop_front();
      n_checked++;
      if (x.w !== w) begin
         $display("%0t: weight expected %h actual %h", $time, x.w, w);
         mismatches++;
      end
      if (x.s !== s) begin
         $display("%0t: step_size expected %h actual %h", $time, x.s, s);
         mismatches++;
      end
      if (x.e !== e) begin
         $display("%0t: index_error expected %b actual %b", $time, x.e, e);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 2 * 1024 + 1100;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_op;
   logic [9:0]         req_sample_index;
   logic [6:0]         req_feature_index;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_weight;
   logic signed [31:0] rsp_step_size;
   logic               rsp_index_error;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;

   lasso_scoreboard sb;
   bit no_idle;
   bit long_hold;
   int idle_cycles;

   lasso_coordinate_descent_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_sample_index(req_sample_index),
      .req_feature_index(req_feature_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_weight(rsp_weight),
      .rsp_step_size(rsp_step_size),
      .rsp_index_error(rsp_index_error),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function int small_value();
      if ($urandom_range(0, 7) == 0) return 0;
      return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   function int any_value();
      if ($urandom_range(0, 2) == 0) return $urandom;
      return small_value();
   endfunction

   task automatic send_req(logic [2:0] op, int si, int fi, int val);
      int g;
      g = no_idle ? 0 : gap_len();
      repeat (g) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_op = op;
      req_sample_index = si[9:0];
      req_feature_index = fi[6:0];
      req_value = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, si, fi, val);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending_q.size() > 0) @(posedge clock);
   endtask

   task automatic write_reg(lcd_pkg::csr_type idx, bit [31:0] data);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_wdata = data;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_write = 0;
   endtask

   task automatic start_phase(bit [31:0] lam, bit [31:0] inv, bit [31:0] ns, bit [31:0] nf);
      int ens;
      int enf;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(lcd_pkg::CSR_LAMBDA, lam);
      write_reg(lcd_pkg::CSR_INV_SAMPLES, inv);
      write_reg(lcd_pkg::CSR_NUM_SAMPLES, ns);
      write_reg(lcd_pkg::CSR_NUM_FEATURES, nf);
      ens = sb.eff_ns();
      enf = sb.eff_nf();
      if (ens * enf <= 96) begin
         for (int i = 0; i < ens; i++) begin
            send_req(lcd_pkg::OP_LOAD_Y, i, $urandom_range(0, 127), any_value());
            for (int j = 0; j < enf; j++)
               send_req(lcd_pkg::OP_LOAD_X, i, j, small_value());
         end
      end
   endtask

   task automatic random_item();
      int r;
      int ns;
      int nf;
      int fi;
      ns = sb.eff_ns();
      nf = sb.eff_nf();
      r = $urandom_range(0, 99);
      if (r < 25) begin
         if ($urandom_range(0, 9) == 0 || ns == 0 || nf == 0)
            send_req(lcd_pkg::OP_LOAD_X, $urandom_range(0, 1023), $urandom_range(0, 127),
                     $urandom);
         else
            send_req(lcd_pkg::OP_LOAD_X, $urandom_range(0, ns - 1),
                     $urandom_range(0, nf - 1), any_value());
      end else if (r < 37) begin
         if ($urandom_range(0, 9) == 0 || ns == 0)
            send_req(lcd_pkg::OP_LOAD_Y, $urandom_range(0, 1023), $urandom_range(0, 127),
                     $urandom);
         else
            send_req(lcd_pkg::OP_LOAD_Y, $urandom_range(0, ns - 1), $urandom_range(0, 127),
                     any_value());
      end else if (r < 77) begin
         if ($urandom_range(0, 9) == 0 || nf == 0)
            fi = $urandom_range(0, 127);
         else
            fi = $urandom_range(0, 2 * nf - 1);
         if (fi < 2 * nf && !sb.column_ready(fi >= nf ? fi - nf : fi))
            send_req(lcd_pkg::OP_READ, $urandom_range(0, 1023), fi % 128, $urandom);
         else
            send_req(lcd_pkg::OP_STEP, $urandom_range(0, 1023), fi, $urandom);
      end else if (r < 92) begin
         send_req(lcd_pkg::OP_READ, $urandom_range(0, 1023),
                  (nf == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, nf - 1),
                  $urandom);
      end else if (r < 96) begin
         send_req(lcd_pkg::OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 127),
                  $urandom);
      end else begin
         send_req($urandom_range(5, 7), $urandom_range(0, 1023), $urandom_range(0, 127),
                  $urandom);
      end
   endtask

   initial begin
      int rsp_hold;
      int rsp_run;
      rsp_stall = 0;
      rsp_run = 0;
      rsp_hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 0;
            rsp_hold = 400;
         end
         if (rsp_hold > 0) begin
            rsp_stall = 1;
            rsp_hold--;
         end else if (rsp_run > 0) begin
            rsp_stall = 1;
            rsp_run--;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_run = gap_len();
            rsp_stall = (rsp_run > 0);
         end else begin
            rsp_stall = 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_weight, rsp_step_size, rsp_index_error);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d quiet cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      sb = new();
      no_idle = 0;
      long_hold = 0;
      idle_cycles = 0;
      reset = 1;
      req_valid = 0;
      req_op = lcd_pkg::OP_LOAD_X;
      req_sample_index = 0;
      req_feature_index = 0;
      req_value = 0;
      csr_write = 0;
      csr_index = lcd_pkg::CSR_LAMBDA;
      csr_wdata = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part at the reset settings: one sample, one feature.
      send_req(lcd_pkg::OP_LOAD_X, 0, 0, 32'sh7FFF_FFFF);
      send_req(lcd_pkg::OP_LOAD_Y, 0, 0, 32'sh8000_0000);
      send_req(lcd_pkg::OP_STEP, 0, 0, 0);
      send_req(lcd_pkg::OP_STEP, 0, 1, 0);
      send_req(lcd_pkg::OP_READ, 0, 0, 0);
      send_req(lcd_pkg::OP_READ, 0, 1, 0);
      send_req(lcd_pkg::OP_LOAD_X, 1, 0, 0);
      send_req(lcd_pkg::OP_LOAD_X, 0, 1, 0);
      send_req(lcd_pkg::OP_LOAD_Y, 1023, 127, 32'shFFFF_FFFF);
      send_req(lcd_pkg::OP_STEP, 1023, 2, 0);
      send_req(lcd_pkg::OP_STEP, 0, 127, 0);
      send_req(3'd5, 0, 0, 0);
      send_req(3'd6, 0, 0, 0);
      send_req(3'd7, 1023, 127, 32'shFFFF_FFFF);
      send_req(lcd_pkg::OP_CLEAR, 0, 0, 0);
      send_req(lcd_pkg::OP_READ, 0, 0, 0);
      send_req(lcd_pkg::OP_LOAD_X, 0, 0, 32'sh8000_0000);
      send_req(lcd_pkg::OP_LOAD_Y, 0, 0, 32'sh7FFF_FFFF);
      send_req(lcd_pkg::OP_STEP, 0, 1, 0);
      send_req(lcd_pkg::OP_STEP, 0, 0, 0);
      send_req(lcd_pkg::OP_READ, 0, 0, 0);

      // Largest sizes with field masking; no descent steps are sent here.
      start_phase(32'hFFFF_FFFF, 32'h0020_0000, 32'd2047, 32'd127);
      send_req(lcd_pkg::OP_LOAD_X, 1023, 63, $urandom);
      send_req(lcd_pkg::OP_LOAD_Y, 1023, 0, $urandom);
      send_req(lcd_pkg::OP_READ, 0, 63, 0);
      send_req(lcd_pkg::OP_READ, 0, 64, 0);
      send_req(lcd_pkg::OP_READ, 0, 127, 0);
      repeat (10) random_item();

      // Zero counts put every index out of range.
      start_phase(32'h0, 32'h0, 32'd0, 32'd0);
      repeat (8) random_item();

      start_phase(32'h7FFF_FFFF, 32'h0, 32'd4, 32'd3);
      repeat (25) random_item();

      // Long receiver hold while the sender keeps offering requests.
      start_phase($urandom_range(0, 32'h0004_0000), 32'h2000_0000, 32'd4, 32'd4);
      long_hold = 1;
      no_idle = 1;
      repeat (30) random_item();
      no_idle = 0;

      for (int k = 0; k < 4; k++) begin
         start_phase($urandom_range(0, 32'h0002_0000), $urandom, $urandom_range(1, 8),
                     $urandom_range(1, 6));
         no_idle = (k == 2);
         repeat (20) random_item();
         no_idle = 0;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d descent steps, %0d weight reads and %0d index errors;",
               sb.n_steps, sb.n_reads, sb.n_errors);
      $display("%0d responses checked across several register settings.", sb.n_checked);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d expected responses never arrived", sb.pending_q.size());
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
